// File: hdl/lare_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lare_pkg
// Types and constants shared by the linear attack/release envelope block.
// ----------------------------------------------------------------------------
package lare_pkg;

  localparam int AMP_FRAC_BITS  = 24;
  localparam int TIME_FRAC_BITS = 16;

  localparam int LEVEL_W = AMP_FRAC_BITS + 1;
  localparam int TIME_W  = 24;
  localparam int KEY_W   = 16;
  localparam int RATE_W  = 18;
  localparam int PROD_W  = RATE_W + TIME_W;
  localparam int QUOT_W  = AMP_FRAC_BITS + TIME_FRAC_BITS + 1;
  localparam int DIV_STEPS = QUOT_W;
  localparam int CNT_W   = $clog2(DIV_STEPS);

  localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(44100);
  localparam logic [KEY_W-1:0]   KEY_HALF   = KEY_W'(32768);
  localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(1) << AMP_FRAC_BITS;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_IDLE   = 2'd0;
  localparam phase_t PH_ATTACK = 2'd1;
  localparam phase_t PH_FULL   = 2'd2;
  localparam phase_t PH_DECAY  = 2'd3;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic div_first;
    logic update;
    logic out_load;
  } lare_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } lare_sts_t;

endpackage
`default_nettype wire

// File: hdl/lare_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lare_ifs
// Valid/ready channels of the envelope block: sample input, level output and
// the sample rate configuration write.
// ----------------------------------------------------------------------------
interface lare_in_if;
  logic                             valid;
  logic                             ready;
  logic [lare_pkg::TIME_W-1:0]      attack_time;
  logic [lare_pkg::TIME_W-1:0]      decay_time;
  logic [lare_pkg::KEY_W-1:0]       key_level;
  modport source (output valid, attack_time, decay_time, key_level, input ready);
  modport sink   (input valid, attack_time, decay_time, key_level, output ready);
endinterface

interface lare_out_if;
  logic                             valid;
  logic                             ready;
  logic [lare_pkg::LEVEL_W-1:0]     level;
  logic                             finished;
  modport source (output valid, level, finished, input ready);
  modport sink   (input valid, level, finished, output ready);
endinterface

interface lare_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lare_pkg::RATE_W-1:0]      sample_rate;
  modport source (output valid, sample_rate, input ready);
  modport sink   (input valid, sample_rate, output ready);
endinterface
`default_nettype wire

// File: hdl/lare_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lare_ctrl
// Sequencer for one sample: load, multiply and bit-serial divide (in attack
// or decay only), update and hand the result to the output register.
// ----------------------------------------------------------------------------
module lare_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  lare_pkg::lare_sts_t  sts,
  output lare_pkg::lare_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [lare_pkg::CNT_W-1:0] DIV_LAST =
    lare_pkg::CNT_W'(lare_pkg::DIV_STEPS - 1);

  logic [2:0]                 state_r, state_nxt;
  logic [lare_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        state_nxt = sts.need_div ? S_MUL : S_UPD;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == '0);
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_UPD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/lare_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lare_dp
// Envelope datapath: phase and amplitude state, step multiplier, restoring
// divider one quotient bit per cycle, and the output register.
// ----------------------------------------------------------------------------
module lare_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  lare_pkg::lare_cmd_t              cmd,
  output lare_pkg::lare_sts_t              sts,
  input  wire                              cfg_we,
  input  wire  [lare_pkg::RATE_W-1:0]      cfg_rate,
  input  wire  [lare_pkg::TIME_W-1:0]      in_attack_time,
  input  wire  [lare_pkg::TIME_W-1:0]      in_decay_time,
  input  wire  [lare_pkg::KEY_W-1:0]       in_key_level,
  input  wire                              out_ready,
  output logic                             out_valid,
  output logic [lare_pkg::LEVEL_W-1:0]     out_level,
  output logic                             out_finished
);

  localparam int PW = lare_pkg::PROD_W;
  localparam int QW = lare_pkg::QUOT_W;
  localparam int LW = lare_pkg::LEVEL_W;

  logic [lare_pkg::RATE_W-1:0] rate_r;
  lare_pkg::phase_t            phase_r;
  logic [LW-1:0]               amp_r;
  logic [lare_pkg::KEY_W-1:0]  last_key_r;
  logic [lare_pkg::KEY_W-1:0]  key_r;
  logic [lare_pkg::TIME_W-1:0] atk_r;
  logic [lare_pkg::TIME_W-1:0] dec_r;
  logic [PW-1:0]               prod_r;
  logic [PW-1:0]               rem_r;
  logic [QW-1:0]               quot_r;
  logic                        done_r;
  logic                        out_valid_r;
  logic [LW-1:0]               level_r;
  logic                        finished_r;

  logic                        rising;
  logic [lare_pkg::TIME_W-1:0] time_sel;
  logic [PW:0]                 trial;
  logic [PW:0]                 divisor;
  logic                        ge;
  logic [LW-1:0]               step;
  logic [LW:0]                 sum;

  assign rising   = (last_key_r <= lare_pkg::KEY_HALF) && (in_key_level > lare_pkg::KEY_HALF);
  assign time_sel = (phase_r == lare_pkg::PH_ATTACK) ? atk_r : dec_r;

  // The dividend is a single one at the top quotient position, so it enters
  // on the first step only.
  assign trial   = cmd.div_first ? (PW+1)'(1) : {rem_r, 1'b0};
  assign divisor = {1'b0, prod_r};
  assign ge      = (trial >= divisor);

  // Any quotient at or above full scale acts the same as full scale on the
  // amplitude, so the step is clamped there.
  always_comb begin
    if (prod_r == '0) begin
      step = lare_pkg::FULL_SCALE;
    end else if (quot_r == '0) begin
      step = LW'(1);
    end else if (quot_r >= QW'(lare_pkg::FULL_SCALE)) begin
      step = lare_pkg::FULL_SCALE;
    end else begin
      step = quot_r[LW-1:0];
    end
  end

  assign sum = {1'b0, amp_r} + {1'b0, step};

  assign sts.need_div = (phase_r == lare_pkg::PH_ATTACK) || (phase_r == lare_pkg::PH_DECAY);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r     <= lare_pkg::RATE_RESET;
      phase_r    <= lare_pkg::PH_IDLE;
      amp_r      <= '0;
      last_key_r <= '0;
      done_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate_r <= cfg_rate;
      end
      if (cmd.load) begin
        if (rising) begin
          phase_r <= lare_pkg::PH_ATTACK;
        end
        last_key_r <= in_key_level;
      end
      if (cmd.update) begin
        done_r <= 1'b0;
        unique case (phase_r)
          lare_pkg::PH_ATTACK: begin
            if (sum >= {1'b0, lare_pkg::FULL_SCALE}) begin
              amp_r   <= lare_pkg::FULL_SCALE;
              phase_r <= lare_pkg::PH_FULL;
            end else begin
              amp_r <= sum[LW-1:0];
            end
          end
          lare_pkg::PH_FULL: begin
            if (key_r < lare_pkg::KEY_HALF) begin
              phase_r <= lare_pkg::PH_DECAY;
            end
          end
          lare_pkg::PH_DECAY: begin
            if (step >= amp_r) begin
              amp_r   <= '0;
              done_r  <= 1'b1;
              phase_r <= lare_pkg::PH_IDLE;
            end else begin
              amp_r <= amp_r - step;
            end
          end
          lare_pkg::PH_IDLE: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key_level;
      atk_r <= in_attack_time;
      dec_r <= in_decay_time;
    end
    if (cmd.mul) begin
      prod_r <= PW'(rate_r) * PW'(time_sel);
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? PW'(trial - divisor) : trial[PW-1:0];
      quot_r <= {quot_r[QW-2:0], ge};
    end
  end

  // Output register: a finished beat waits here while the next sample runs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      level_r    <= amp_r;
      finished_r <= done_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_level    = level_r;
  assign out_finished = finished_r;

endmodule
`default_nettype wire

// File: hdl/linear_ar_envelope_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_ar_envelope_core
// Linear attack/release envelope generator, one result beat per sample beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries one audio sample tick: attack and decay times (Q8.16 s)
//   and the key level (Q0.16). out_bus returns the envelope level
//   (1.0 = 2^24) and a one-beat finished flag when a decay hits zero.
//   cfg_bus writes the sample rate; it is always ready and should only be
//   written while no sample is in flight.
// Sequence and throughput:
//   A sample in attack or decay goes from the input beat through the
//   multiply, then a restoring divider producing one of 41 quotient bits
//   per cycle, then the update and the output load. A sample in idle or
//   full skips the multiply and divide. One sample is processed at a time;
//   in_bus.ready is high only between samples, so a new beat is not taken
//   until the previous result has been loaded into the output register.
// Reset: phase idle, amplitude zero, previous key zero, sample rate 44100.
// Stall: a result waits in the output register while the next sample is
//   accepted and computed; that sample then waits until the register frees.
// ----------------------------------------------------------------------------
module linear_ar_envelope_core (
  input  wire        clk,
  input  wire        rst_n,
  lare_in_if.sink    in_bus,
  lare_out_if.source out_bus,
  lare_cfg_if.sink   cfg_bus
);

  lare_pkg::lare_cmd_t cmd;
  lare_pkg::lare_sts_t sts;

  assign cfg_bus.ready = 1'b1;

  lare_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lare_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_bus.valid),
    .cfg_rate       (cfg_bus.sample_rate),
    .in_attack_time (in_bus.attack_time),
    .in_decay_time  (in_bus.decay_time),
    .in_key_level   (in_bus.key_level),
    .out_ready      (out_bus.ready),
    .out_valid      (out_bus.valid),
    .out_level      (out_bus.level),
    .out_finished   (out_bus.finished)
  );

endmodule
`default_nettype wire

// File: hdl/lare_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lare_checker
// Port-level checks of the envelope block, bound to the top level.
// ----------------------------------------------------------------------------
module lare_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [lare_pkg::LEVEL_W-1:0]  out_level,
  input wire                          out_finished
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_finished))
    else $error("output beat changed while stalled");

  // The finished pulse only comes with a level clamped to zero.
  a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_level == '0)
    else $error("finished beat with nonzero level");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level <= lare_pkg::FULL_SCALE)
    else $error("level above full scale");

  // One sample at a time: the input closes right after a beat is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted beat");

endmodule

bind linear_ar_envelope_core lare_checker u_lare_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .out_level    (out_bus.level),
  .out_finished (out_bus.finished)
);
`default_nettype wire

// File: tb/envelope_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// envelope_checker
// Watches the sample, level and sample rate channels of the envelope core.
// It keeps its own copy of the envelope state, works out the level and the
// finished flag for every accepted sample, and compares them in order with
// the level beats that the core returns.
// ----------------------------------------------------------------------------
module envelope_checker (
  input  wire  clk,
  input  wire  rst_n,
  lare_in_if   in_bus,
  lare_out_if  out_bus,
  lare_cfg_if  cfg_bus,
  output int   fail_count,
  output int   pending_cnt
);

  typedef struct packed {
    logic [lare_pkg::LEVEL_W-1:0] level;
    logic                         finished;
  } env_beat_t;

  env_beat_t                    levels_due[$];
  lare_pkg::phase_t             env_phase;
  logic [lare_pkg::LEVEL_W-1:0] env_amp;
  logic [lare_pkg::KEY_W-1:0]   prev_key;
  logic [lare_pkg::RATE_W-1:0]  rate;

  initial begin
    fail_count  = 0;
    pending_cnt = 0;
    env_phase   = lare_pkg::PH_IDLE;
    env_amp     = '0;
    prev_key    = '0;
    rate        = lare_pkg::RATE_RESET;
  end

  // Per-sample step for a duration; a zero product (zero time or zero rate)
  // jumps by full scale, and a tiny quotient is held at one.
  function automatic logic [lare_pkg::QUOT_W-1:0] slope_for(
      input logic [lare_pkg::TIME_W-1:0] dur);
    logic [lare_pkg::PROD_W-1:0] prod;
    logic [lare_pkg::QUOT_W-1:0] quot;
    prod = lare_pkg::PROD_W'(rate) * lare_pkg::PROD_W'(dur);
    if (prod == '0) return lare_pkg::QUOT_W'(lare_pkg::FULL_SCALE);
    quot = lare_pkg::QUOT_W'((64'd1 << (lare_pkg::AMP_FRAC_BITS + lare_pkg::TIME_FRAC_BITS))
                             / 64'(prod));
    return (quot == '0) ? lare_pkg::QUOT_W'(1) : quot;
  endfunction

  function automatic env_beat_t next_envelope(input logic [lare_pkg::TIME_W-1:0] atk,
                                              input logic [lare_pkg::TIME_W-1:0] dcy,
                                              input logic [lare_pkg::KEY_W-1:0] key);
    env_beat_t                   beat;
    logic [lare_pkg::QUOT_W:0]   sum;
    logic [lare_pkg::QUOT_W-1:0] step;
    beat.finished = 1'b0;
    if (prev_key <= lare_pkg::KEY_HALF && key > lare_pkg::KEY_HALF)
      env_phase = lare_pkg::PH_ATTACK;
    prev_key = key;
    case (env_phase)
      lare_pkg::PH_ATTACK: begin
        sum = (lare_pkg::QUOT_W + 1)'(env_amp) + (lare_pkg::QUOT_W + 1)'(slope_for(atk));
        if (sum >= (lare_pkg::QUOT_W + 1)'(lare_pkg::FULL_SCALE)) begin
          env_amp   = lare_pkg::FULL_SCALE;
          env_phase = lare_pkg::PH_FULL;
        end else begin
          env_amp = lare_pkg::LEVEL_W'(sum);
        end
      end
      lare_pkg::PH_FULL: begin
        if (key < lare_pkg::KEY_HALF) env_phase = lare_pkg::PH_DECAY;
      end
      lare_pkg::PH_DECAY: begin
        step = slope_for(dcy);
        if (step >= lare_pkg::QUOT_W'(env_amp)) begin
          env_amp       = '0;
          beat.finished = 1'b1;
          env_phase     = lare_pkg::PH_IDLE;
        end else begin
          env_amp = env_amp - lare_pkg::LEVEL_W'(step);
        end
      end
      default: ;
    endcase
    beat.level = env_amp;
    return beat;
  endfunction

  function automatic void flag_mismatch(input string what, input longint want,
                                        input longint got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endfunction

  always @(posedge clk) begin : watch
    env_beat_t want;
    if (!rst_n) begin
      env_phase = lare_pkg::PH_IDLE;
      env_amp   = '0;
      prev_key  = '0;
      rate      = lare_pkg::RATE_RESET;
      levels_due.delete();
    end else begin
      // An output beat can never belong to a sample accepted on the same edge.
      if (out_bus.valid && out_bus.ready) begin
        if (levels_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t ns: level beat with none pending: level %0d, finished %0d",
                     $time, out_bus.level, out_bus.finished);
        end else begin
          want = levels_due.pop_front();
          if (out_bus.level !== want.level)
            flag_mismatch("level", want.level, out_bus.level);
          if (out_bus.finished !== want.finished)
            flag_mismatch("finished", want.finished, out_bus.finished);
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) rate = cfg_bus.sample_rate;
      if (in_bus.valid && in_bus.ready)
        levels_due.push_back(next_envelope(in_bus.attack_time, in_bus.decay_time,
                                           in_bus.key_level));
    end
    pending_cnt <= levels_due.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the linear attack/release envelope core: directed edge cases,
// then random key-on/key-off notes and noise samples under several sample
// rates, with random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_ITEMS    = 70;
  localparam logic [lare_pkg::TIME_W-1:0] TIME_MAX = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  lare_in_if  in_bus ();
  lare_out_if out_bus ();
  lare_cfg_if cfg_bus ();

  int fail_count;
  int pending_cnt;

  linear_ar_envelope_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  envelope_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_bus     (cfg_bus),
    .fail_count  (fail_count),
    .pending_cnt (pending_cnt)
  );

  int                          items_sent = 0;
  int                          hold_asks  = 0;
  logic                        quiet_tail = 1'b0;
  logic                        tx_bursty  = 1'b1;
  logic [lare_pkg::RATE_W-1:0] cur_rate   = lare_pkg::RATE_RESET;
  int                          stall_cycles = 0;

  // Watchdog: ends the run when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Level receiver: random back-pressure bursts, and a long hold-off on request.
  initial begin : level_sink
    int   hold_left;
    int   asks_seen;
    logic bursty;
    hold_left = 0;
    asks_seen = 0;
    bursty    = 1'b1;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 299) == 0) bursty = !bursty;
      if (hold_asks != asks_seen) begin
        asks_seen = hold_asks;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && !quiet_tail && bursty &&
                   $urandom_range(0, 11) == 0) begin
        hold_left = $urandom_range(1, 14);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [lare_pkg::TIME_W-1:0] atk,
                             input logic [lare_pkg::TIME_W-1:0] dcy,
                             input logic [lare_pkg::KEY_W-1:0] key);
    if (!quiet_tail && tx_bursty && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.attack_time <= atk;
    in_bus.decay_time  <= dcy;
    in_bus.key_level   <= key;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
  endtask

  // Stops offering samples and waits until every pending level beat is back.
  task automatic drain_levels();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  task automatic write_rate(input logic [lare_pkg::RATE_W-1:0] new_rate);
    drain_levels();
    repeat (4) @(posedge clk);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.sample_rate <= new_rate;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    cur_rate = new_rate;
  endtask

  // Mostly picks a duration that ramps in roughly 1 to 40 samples at the
  // present rate, so notes get through attack and decay.
  function automatic logic [lare_pkg::TIME_W-1:0] pick_time();
    int unsigned pick;
    longint      span;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return lare_pkg::TIME_W'($urandom);
    span = (longint'($urandom_range(1, 40)) * 65536) /
           longint'((cur_rate == '0) ? 1 : cur_rate);
    span = span + $urandom_range(0, 3);
    if (span > longint'(TIME_MAX)) span = longint'(TIME_MAX);
    return lare_pkg::TIME_W'(span);
  endfunction

  task automatic play_note();
    logic [lare_pkg::TIME_W-1:0] atk;
    logic [lare_pkg::TIME_W-1:0] dcy;
    logic [lare_pkg::KEY_W-1:0]  key;
    int                          n_on;
    int                          n_off;
    atk   = pick_time();
    dcy   = pick_time();
    n_on  = $urandom_range(1, 40);
    n_off = $urandom_range(1, 40);
    for (int i = 0; i < n_on; i++) begin
      if ($urandom_range(0, 15) == 0) atk = pick_time();
      key = ($urandom_range(0, 19) == 0) ? lare_pkg::KEY_HALF
                                         : lare_pkg::KEY_W'($urandom_range(32769, 65535));
      send_sample(atk, dcy, key);
    end
    for (int i = 0; i < n_off; i++) begin
      if ($urandom_range(0, 15) == 0) dcy = pick_time();
      key = ($urandom_range(0, 19) == 0) ? lare_pkg::KEY_HALF
                                         : lare_pkg::KEY_W'($urandom_range(0, 32767));
      send_sample(atk, dcy, key);
    end
  endtask

  task automatic play_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      send_sample(lare_pkg::TIME_W'($urandom), lare_pkg::TIME_W'($urandom),
                  lare_pkg::KEY_W'($urandom));
  endtask

  task automatic play_phase(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      tx_bursty = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) play_noise();
      else play_note();
      if ($urandom_range(0, 24) == 0) drain_levels();
    end
  endtask

  initial begin : stimulus
    in_bus.valid        = 1'b0;
    in_bus.attack_time  = '0;
    in_bus.decay_time   = '0;
    in_bus.key_level    = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.sample_rate = lare_pkg::RATE_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples at the reset sample rate.
    send_sample('0, '0, '0);
    send_sample('0, '0, lare_pkg::KEY_HALF);      // exactly half is no edge
    send_sample('0, '0, lare_pkg::KEY_HALF + lare_pkg::KEY_W'(1)); // instant attack
    send_sample('0, '0, lare_pkg::KEY_HALF);      // full holds at exactly half
    send_sample('0, '0, 16'hFFFF);                // new edge while full
    send_sample(TIME_MAX, TIME_MAX, lare_pkg::KEY_HALF - lare_pkg::KEY_W'(1)); // to decay
    send_sample(TIME_MAX, TIME_MAX, '0);          // smallest decay step
    send_sample(TIME_MAX, '0, '0);                // instant decay, finished
    send_sample('0, '0, '0);
    send_sample(TIME_MAX, TIME_MAX, 16'hFFFF);    // smallest attack step
    send_sample(TIME_MAX, TIME_MAX, '0);          // attack ignores the key
    send_sample(24'd1, TIME_MAX, '0);             // attack overshoot saturates
    send_sample('0, '0, '0);
    send_sample('0, 24'd40, '0);
    send_sample('0, 24'd40, '0);
    send_sample(24'd40, 24'd40, lare_pkg::KEY_HALF + lare_pkg::KEY_W'(1)); // edge in decay
    send_sample(24'd40, 24'd40, 16'hFFFF);
    send_sample(24'd40, 24'd2, '0);
    send_sample(24'hAAAAAA, 24'h555555, 16'h5555);
    send_sample(24'h555555, 24'hAAAAAA, 16'hAAAA);
    drain_levels();

    play_phase(PHASE_ITEMS);
    write_rate(lare_pkg::RATE_W'(1));
    play_phase(PHASE_ITEMS);
    write_rate('1);
    hold_asks <= hold_asks + 1;
    play_phase(PHASE_ITEMS);
    write_rate('0);
    play_phase(PHASE_ITEMS);
    write_rate(lare_pkg::RATE_W'(48000));
    play_phase(PHASE_ITEMS);
    write_rate(lare_pkg::RATE_W'($urandom_range(2, 262142)));
    play_phase(PHASE_ITEMS);
    write_rate(lare_pkg::RATE_RESET);
    quiet_tail <= 1'b1;
    play_phase(PHASE_ITEMS);

    drain_levels();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
